// File: hdl/sacf_pkg.sv
package sacf_pkg;

	typedef logic [4:0] shamt_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [4:0] cfg_data_t;
	typedef logic [31:0] count_t;

	localparam cfg_idx_t CFG_OFFSET_BITS = 2'd0;
	localparam cfg_idx_t CFG_SET_BITS    = 2'd1;
	localparam cfg_idx_t CFG_WAYS_IN_USE = 2'd2;

	localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
	localparam logic [3:0] SET_BITS_RST    = 4'd0;
	localparam logic [2:0] WAYS_RST        = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_READ,
		ST_CMP,
		ST_UPDATE
	} state_t;

	function automatic count_t sat_inc(count_t v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

// File: hdl/sacf_unit.sv
module sacf_unit #(
	parameter int W = 48
) (
	input  logic [W-1:0]     a,
	input  sacf_pkg::shamt_t amt,
	input  logic [W-1:0]     b,
	output logic [W-1:0]     shifted,
	output logic             eq
);

	// The same shifter splits the address and, with a zero shift, compares tags.
	assign shifted = a >> amt;
	assign eq      = (shifted == b);

endmodule

// File: hdl/sacf_row_ram.sv
module sacf_row_ram #(
	parameter int DEPTH = 256,
	parameter int DW    = 198
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DW-1:0]                       wdata,
	input  logic                                re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DW-1:0]                       rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/set_assoc_cache_fifo.sv
// Set-associative cache tag model with FIFO replacement and write-through.
// Input channel: in_valid, in_stall, op and address; one beat is one access.
// Output channel: out_valid, out_stall and one result beat per access, with
// hit, mem_read, mem_write and the four saturating running totals.
// Configuration channel: cfg_valid, cfg_ready, cfg_index and cfg_data; it is
// always ready. It is to be written only while the block is idle; the block
// itself does not enforce this. An accepted access splits its address, reads
// its set row from the row memory, compares the ways in use in order from way
// 0, stopping at a hit, then writes the row on a miss and loads the result.
// The single shift and compare unit checks one way per cycle, and no new access is taken until the last one is done.
// After reset the block clears the row memory, one set per cycle, and takes no
// access until then; configuration writes are taken during that pass.
// A stalled result stays in the output register. A new access may be
// accepted meanwhile, but it waits in its last cycle until the output
// register is free, and the input stays stalled until then.
module set_assoc_cache_fifo #(
	parameter int SETS      = 256,
	parameter int WAYS      = 4,
	parameter int ADDR_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [ADDR_BITS-1:0]       address,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic                       mem_read,
	output logic                       mem_write,
	output logic [31:0]                hit_total,
	output logic [31:0]                miss_total,
	output logic [31:0]                read_total,
	output logic [31:0]                write_total,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  sacf_pkg::cfg_idx_t         cfg_index,
	input  sacf_pkg::cfg_data_t        cfg_data
);

	localparam int SB_MAX  = $clog2(SETS + 1) - 1;
	localparam int MIW     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCW     = $clog2(WAYS + 1);
	localparam int ENTRY_W = ADDR_BITS + 1;
	localparam int ROW_W   = WAYS * ENTRY_W + WW;
	localparam int KW      = (ADDR_BITS > MIW) ? ADDR_BITS : MIW;

	sacf_pkg::state_t state_q, state_d;

	logic [4:0]           cfg_offset_q;
	logic [3:0]           cfg_set_q;
	logic [2:0]           cfg_ways_q;

	logic [MIW-1:0]       clr_q;
	logic [MIW-1:0]       set_q;
	logic [ADDR_BITS-1:0] key_q;
	logic                 op_q;
	logic [WW-1:0]        idx_q;
	logic                 hit_q;
	logic                 inv_found_q;
	logic [WW-1:0]        inv_idx_q;

	sacf_pkg::count_t     hit_count_q, miss_count_q, read_count_q, write_count_q;
	logic                 out_valid_q, out_hit_q, out_wr_q;

	logic [WCW-1:0]       eff_ways;
	sacf_pkg::shamt_t     sb_eff;
	logic [MIW-1:0]       set_d;
	logic [KW-1:0]        key_ext;

	logic [ADDR_BITS-1:0] u_a, u_shifted;
	sacf_pkg::shamt_t     u_amt;
	logic                 u_eq;

	logic                 ram_we, ram_re;
	logic [MIW-1:0]       ram_waddr;
	logic [ROW_W-1:0]     ram_wdata, ram_rdata;

	logic [ENTRY_W-1:0]   ent [WAYS];
	logic [ENTRY_W-1:0]   cur;
	logic                 cur_valid;
	logic                 cmp_last;
	logic [WW-1:0]        victim_rd, victim_cur, victim_next, slot;
	logic [WCW-1:0]       victim_inc;
	logic [ROW_W-1:0]     fill_row;
	logic                 upd_go;

	always_comb begin
		if (cfg_ways_q == 3'd0) begin
			eff_ways = WCW'(1);
		end else if (32'(cfg_ways_q) > WAYS) begin
			eff_ways = WCW'(WAYS);
		end else begin
			eff_ways = WCW'(cfg_ways_q);
		end
		if (32'(cfg_set_q) > SB_MAX) begin
			sb_eff = sacf_pkg::shamt_t'(SB_MAX);
		end else begin
			sb_eff = sacf_pkg::shamt_t'(cfg_set_q);
		end
	end

	assign key_ext = KW'(key_q);

	always_comb begin
		for (int i = 0; i < MIW; i++) begin
			set_d[i] = key_ext[i] && (i < 32'(sb_eff));
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ent[w] = ram_rdata[w*ENTRY_W +: ENTRY_W];
		end
	end

	assign cur       = ent[idx_q];
	assign cur_valid = cur[ADDR_BITS];
	assign cmp_last  = (WCW'(idx_q) == eff_ways - WCW'(1));
	assign victim_rd = ram_rdata[WAYS*ENTRY_W +: WW];

	always_comb begin
		victim_cur  = (WCW'(victim_rd) >= eff_ways) ? '0 : victim_rd;
		victim_inc  = WCW'(victim_cur) + WCW'(1);
		slot        = inv_found_q ? inv_idx_q : victim_cur;
		if (inv_found_q) begin
			victim_next = victim_rd;
		end else if (victim_inc >= eff_ways) begin
			victim_next = '0;
		end else begin
			victim_next = WW'(victim_inc);
		end
		fill_row = ram_rdata;
		for (int w = 0; w < WAYS; w++) begin
			if (WW'(w) == slot) begin
				fill_row[w*ENTRY_W +: ENTRY_W] = {1'b1, key_q};
			end
		end
		fill_row[WAYS*ENTRY_W +: WW] = victim_next;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = set_q;
		ram_wdata = fill_row;
		upd_go    = 1'b0;
		u_a       = key_q;
		u_amt     = '0;
		unique case (state_q)
			sacf_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == MIW'(SETS - 1)) begin
					state_d = sacf_pkg::ST_IDLE;
				end
			end
			sacf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				u_a      = address;
				u_amt    = cfg_offset_q;
				if (in_valid) begin
					state_d = sacf_pkg::ST_SPLIT;
				end
			end
			sacf_pkg::ST_SPLIT: begin
				u_amt   = sb_eff;
				state_d = sacf_pkg::ST_READ;
			end
			sacf_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = sacf_pkg::ST_CMP;
			end
			sacf_pkg::ST_CMP: begin
				u_a = cur[ADDR_BITS-1:0];
				if ((cur_valid && u_eq) || cmp_last) begin
					state_d = sacf_pkg::ST_UPDATE;
				end
			end
			sacf_pkg::ST_UPDATE: begin
				if (!out_valid_q || !out_stall) begin
					upd_go  = 1'b1;
					ram_we  = !hit_q;
					state_d = sacf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sacf_pkg::ST_IDLE;
			end
		endcase
	end

	sacf_unit #(
		.W(ADDR_BITS)
	) u_unit (
		.a       (u_a),
		.amt     (u_amt),
		.b       (key_q),
		.shifted (u_shifted),
		.eq      (u_eq)
	);

	sacf_row_ram #(
		.DEPTH(SETS),
		.DW   (ROW_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (set_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacf_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sacf_pkg::ST_CLEAR) begin
				clr_q <= clr_q + MIW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_offset_q <= sacf_pkg::OFFSET_BITS_RST;
			cfg_set_q    <= sacf_pkg::SET_BITS_RST;
			cfg_ways_q   <= sacf_pkg::WAYS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sacf_pkg::CFG_OFFSET_BITS: cfg_offset_q <= cfg_data;
				sacf_pkg::CFG_SET_BITS:    cfg_set_q    <= cfg_data[3:0];
				sacf_pkg::CFG_WAYS_IN_USE: cfg_ways_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sacf_pkg::ST_IDLE: begin
				if (in_valid) begin
					key_q <= u_shifted;
					op_q  <= op;
				end
			end
			sacf_pkg::ST_SPLIT: begin
				key_q <= u_shifted;
				set_q <= set_d;
			end
			sacf_pkg::ST_READ: begin
				idx_q       <= '0;
				hit_q       <= 1'b0;
				inv_found_q <= 1'b0;
			end
			sacf_pkg::ST_CMP: begin
				if (cur_valid && u_eq) begin
					hit_q <= 1'b1;
				end else begin
					if (!cur_valid && !inv_found_q) begin
						inv_found_q <= 1'b1;
						inv_idx_q   <= idx_q;
					end
					if (!cmp_last) begin
						idx_q <= idx_q + WW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q   <= '0;
			miss_count_q  <= '0;
			read_count_q  <= '0;
			write_count_q <= '0;
			out_valid_q   <= 1'b0;
			out_hit_q     <= 1'b0;
			out_wr_q      <= 1'b0;
		end else begin
			if (upd_go) begin
				if (hit_q) begin
					hit_count_q <= sacf_pkg::sat_inc(hit_count_q);
				end else begin
					miss_count_q <= sacf_pkg::sat_inc(miss_count_q);
					read_count_q <= sacf_pkg::sat_inc(read_count_q);
				end
				if (op_q) begin
					write_count_q <= sacf_pkg::sat_inc(write_count_q);
				end
				out_valid_q <= 1'b1;
				out_hit_q   <= hit_q;
				out_wr_q    <= op_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The totals change only when a result is loaded, so the count registers
	// themselves hold the totals of the beat in the output register.
	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign mem_read    = !out_hit_q;
	assign mem_write   = out_wr_q;
	assign hit_total   = hit_count_q;
	assign miss_total  = miss_count_q;
	assign read_total  = read_count_q;
	assign write_total = write_count_q;
	assign cfg_ready   = 1'b1;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sacf_pkg::ST_CMP |-> WCW'(idx_q) < eff_ways)
		else $error("way index beyond the ways in use");

	a_counts_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hit_count_q >= $past(hit_count_q) && miss_count_q >= $past(miss_count_q))
		else $error("hit or miss total went down");

	a_update_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> out_valid_q && state_q == sacf_pkg::ST_IDLE)
		else $error("finished access did not reach the output register");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(hit_count_q) && $stable(miss_count_q)
			&& $stable(read_count_q) && $stable(write_count_q))
		else $error("totals changed under a stalled result");

endmodule

// File: verif/set_assoc_cache_fifo_tb.sv
module set_assoc_cache_fifo_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS = 256;
	localparam int WAYS = 4;
	localparam int ADDR_BITS = 48;
	localparam int MAX_SET_BITS = $clog2(SETS);
	localparam int WATCHDOG_LIMIT = 4000;
	localparam sacf_pkg::cfg_idx_t CFG_SPARE = 2'd3;

	typedef struct packed {
		logic             hit;
		logic             mem_read;
		logic             mem_write;
		sacf_pkg::count_t hit_total;
		sacf_pkg::count_t miss_total;
		sacf_pkg::count_t read_total;
		sacf_pkg::count_t write_total;
	} lookup_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 op = 1'b0;
	logic [ADDR_BITS-1:0] address = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic                 mem_read;
	logic                 mem_write;
	logic [31:0]          hit_total;
	logic [31:0]          miss_total;
	logic [31:0]          read_total;
	logic [31:0]          write_total;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	sacf_pkg::cfg_idx_t   cfg_index = sacf_pkg::CFG_OFFSET_BITS;
	sacf_pkg::cfg_data_t  cfg_data = '0;

	set_assoc_cache_fifo #(
		.SETS(SETS),
		.WAYS(WAYS),
		.ADDR_BITS(ADDR_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.mem_read(mem_read),
		.mem_write(mem_write),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.read_total(read_total),
		.write_total(write_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [4:0]           cur_offset = sacf_pkg::OFFSET_BITS_RST;
	logic [3:0]           cur_set_bits = sacf_pkg::SET_BITS_RST;
	logic [2:0]           cur_ways = sacf_pkg::WAYS_RST;
	bit                   line_ok [SETS][WAYS];
	logic [ADDR_BITS-1:0] line_tag_q [SETS][WAYS];
	int                   next_victim [SETS];
	sacf_pkg::count_t     hits_so_far = '0;
	sacf_pkg::count_t     misses_so_far = '0;
	sacf_pkg::count_t     reads_so_far = '0;
	sacf_pkg::count_t     writes_so_far = '0;
	lookup_result_t       pending_results [$];

	int                   errors = 0;
	int                   out_hold = 0;
	int                   quiet_cycles = 0;
	bit                   idle_in = 1'b1;
	bit                   idle_out = 1'b1;

	function automatic int eff_ways();
		int w;
		w = cur_ways;
		if (w == 0) begin
			w = 1;
		end
		if (w > WAYS) begin
			w = WAYS;
		end
		return w;
	endfunction

	function automatic int eff_set_bits();
		return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
	endfunction

	function automatic void predict_lookup(input logic wr, input logic [ADDR_BITS-1:0] a);
		logic [ADDR_BITS-1:0] blk;
		logic [ADDR_BITS-1:0] tg;
		int                   nw;
		int                   sb;
		int                   set_i;
		int                   slot;
		int                   v;
		bit                   found;
		lookup_result_t       r;
		nw = eff_ways();
		sb = eff_set_bits();
		blk = a >> cur_offset;
		set_i = int'(blk & ((48'd1 << sb) - 48'd1));
		tg = blk >> sb;
		found = 1'b0;
		for (int w = 0; w < nw && !found; w++) begin
			if (line_ok[set_i][w] && line_tag_q[set_i][w] == tg) begin
				found = 1'b1;
			end
		end
		if (found) begin
			if (hits_so_far != '1) hits_so_far++;
		end else begin
			slot = nw;
			for (int w = 0; w < nw && slot == nw; w++) begin
				if (!line_ok[set_i][w]) begin
					slot = w;
				end
			end
			if (slot == nw) begin
				v = next_victim[set_i];
				if (v >= nw) begin
					v = 0;
				end
				slot = v;
				v++;
				if (v >= nw) begin
					v = 0;
				end
				next_victim[set_i] = v;
			end
			line_ok[set_i][slot] = 1'b1;
			line_tag_q[set_i][slot] = tg;
			if (misses_so_far != '1) misses_so_far++;
			if (reads_so_far != '1) reads_so_far++;
		end
		if (wr && writes_so_far != '1) writes_so_far++;
		r.hit = found;
		r.mem_read = !found;
		r.mem_write = wr;
		r.hit_total = hits_so_far;
		r.miss_total = misses_so_far;
		r.read_total = reads_so_far;
		r.write_total = writes_so_far;
		pending_results.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		lookup_result_t got;
		lookup_result_t want;
		int w;
		if (out_valid && !out_stall) begin
			got = {hit, mem_read, mem_write, hit_total, miss_total, read_total, write_total};
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with no access pending, expected none actual %h",
					$time, got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(got.hit));
				check_field("mem_read", 32'(want.mem_read), 32'(got.mem_read));
				check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
				check_field("hit_total", want.hit_total, got.hit_total);
				check_field("miss_total", want.miss_total, got.miss_total);
				check_field("read_total", want.read_total, got.read_total);
				check_field("write_total", want.write_total, got.write_total);
			end
			w = idle_out ? $urandom_range(0, 7) : 0;
			out_stall <= (w != 0);
			out_hold <= w;
		end else if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_stall <= (out_hold > 1);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL set_assoc_cache_fifo");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_access(input logic wr, input logic [ADDR_BITS-1:0] a);
		int gap;
		gap = idle_in ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= wr;
		address <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_lookup(wr, a);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input sacf_pkg::cfg_idx_t idx, input sacf_pkg::cfg_data_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			sacf_pkg::CFG_OFFSET_BITS: begin
				cur_offset = d;
			end
			sacf_pkg::CFG_SET_BITS: begin
				cur_set_bits = d[3:0];
			end
			sacf_pkg::CFG_WAYS_IN_USE: begin
				cur_ways = d[2:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input sacf_pkg::cfg_data_t ob, input sacf_pkg::cfg_data_t sb,
			input sacf_pkg::cfg_data_t w);
		write_reg(sacf_pkg::CFG_OFFSET_BITS, ob);
		write_reg(sacf_pkg::CFG_SET_BITS, sb);
		write_reg(sacf_pkg::CFG_WAYS_IN_USE, w);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADDR_BITS-1:0] make_addr();
		logic [63:0] a;
		int          sb;
		sb = eff_set_bits();
		if ($urandom_range(0, 9) < 8) begin
			a = (64'($urandom_range(0, 5)) << (cur_offset + sb))
				| (64'($urandom_range(0, 2)) << cur_offset)
				| (64'($urandom) & ((64'd1 << cur_offset) - 64'd1));
		end else begin
			a = {$urandom, $urandom};
		end
		return a[ADDR_BITS-1:0];
	endfunction

	task automatic test_reset_config();
		idle_in = 1'b1;
		idle_out = 1'b0;
		send_access(1'b0, 48'h0);
		send_access(1'b1, 48'h0);
		send_access(1'b0, 48'hF);
		send_access(1'b1, 48'h10);
		send_access(1'b0, '1);
		drain();
	endtask

	task automatic test_fifo_order();
		idle_out = 1'b1;
		set_config(5'd0, 5'd0, 5'd4);
		send_access(1'b0, 48'h0);
		send_access(1'b0, 48'h1);
		send_access(1'b1, 48'h200);
		send_access(1'b0, 48'h300);
		send_access(1'b0, 48'h0);
		send_access(1'b0, 48'h200);
		send_access(1'b1, 48'h400);
		send_access(1'b0, 48'h500);
		send_access(1'b0, 48'h200);
		drain();
	endtask

	task automatic test_config_corners();
		// Oversized fields: set count and associativity saturate, zero ways acts as one.
		set_config(5'd31, 5'd31, 5'd0);
		send_access(1'b1, '1);
		send_access(1'b0, 48'h8000_0000_0000);
		send_access(1'b0, '1);
		drain();
		set_config(5'd16, 5'd8, 5'd7);
		write_reg(CFG_SPARE, 5'd1);
		cfg_valid <= 1'b0;
		send_access(1'b0, 48'h5A5A_0000_0000);
		send_access(1'b1, 48'h5A5A_00FF_FFFF);
		drain();
		// Three ways in use: the victim pointer must wrap before way three.
		set_config(5'd4, 5'd0, 5'd3);
		send_access(1'b0, 48'h1000);
		send_access(1'b1, 48'h2000);
		send_access(1'b0, 48'h3000);
		send_access(1'b0, 48'h4000);
		drain();
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 10; p++) begin
			idle_in = (p % 3 != 1);
			idle_out = (p % 3 != 2);
			case (p)
				0: set_config(5'd0, 5'd0, 5'd1);
				1: set_config(5'd16, 5'd8, 5'd4);
				2: set_config(5'd0, 5'd15, 5'd2);
				default: set_config(sacf_pkg::cfg_data_t'($urandom_range(0, 31)),
					sacf_pkg::cfg_data_t'($urandom_range(0, 31)),
					sacf_pkg::cfg_data_t'($urandom_range(0, 7)));
			endcase
			for (int i = 0; i < 52; i++) begin
				send_access(1'($urandom_range(0, 1)), make_addr());
			end
			drain();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_config();
		test_fifo_order();
		test_config_corners();
		test_random_traffic();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS set_assoc_cache_fifo");
		end else begin
			$display("FAIL set_assoc_cache_fifo");
		end
		$finish;
	end

endmodule
